// ----- rtl/hie_pkg.sv -----
// Package for the Hermite interpolation evaluator: state and tag enums,
// result codes, the saturating adder and the interface structs of the
// shared multiply-divide unit. Depends on nothing.
`default_nettype none

package hie_pkg;

    // Internal values are kept within +-LIM.
    localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COINC = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [5:0] MUL_LAST = 6'd4;
    localparam logic [5:0] DIV_LAST = 6'd63;

    localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_FIN
    } md_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_I,
        S_CHK_W,
        S_CHK_C,
        S_EV_I,
        S_EV_W,
        S_EV_J,
        S_MD,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        T_BASIS,
        T_INV,
        T_SQ,
        T_U,
        T_A,
        T_B,
        T_VA,
        T_MB
    } tag_t;

    typedef struct packed {
        logic               go;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic signed [63:0] q;
    } md_rsp_t;

    typedef struct packed {
        logic               hit;
        logic signed [63:0] val;
    } sat_t;

    function automatic sat_t sat_add(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        sat_t               r;
        s     = {a[63], a} + {b[63], b};
        r.hit = 1'b0;
        r.val = s[63:0];
        if (s > 65'(LIM)) begin
            r.hit = 1'b1;
            r.val = LIM;
        end else if (s < -65'(LIM)) begin
            r.hit = 1'b1;
            r.val = -LIM;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hie_muldiv.sv -----
// Shared multiply-divide unit: q = a*b/c, exact, truncated toward zero and
// clamped to +-LIM. A 32x32 multiplier builds the product from four partial
// products, then a restoring divider takes one quotient bit a cycle. Uses hie_pkg.
`default_nettype none

module hie_muldiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hie_pkg::md_req_t req,
    output hie_pkg::md_rsp_t     rsp
);
    import hie_pkg::*;

    md_state_t    st_reg, st_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [63:0]  ua_reg, ua_next;
    logic [63:0]  ub_reg, ub_next;
    logic [63:0]  uc_reg, uc_next;
    logic         neg_reg, neg_next;
    logic [63:0]  pp_reg, pp_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  rem_reg, rem_next;
    logic         done_reg, done_next;
    logic         hit_reg, hit_next;
    logic signed [63:0] q_reg, q_next;

    logic [1:0]   pc, pprev;
    logic [31:0]  ah, bh;
    logic [127:0] ppx;
    logic [64:0]  rem2;
    logic         ge;
    logic [63:0]  qm;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            MD_IDLE: begin
                if (req.go && req.a != 64'sd0 && req.b != 64'sd0) begin
                    st_next = MD_MUL;
                end
            end
            MD_MUL: begin
                if (cnt_reg == MUL_LAST) begin
                    st_next = MD_CHK;
                end
            end
            MD_CHK: begin
                st_next = (acc_reg[127:64] >= uc_reg) ? MD_IDLE : MD_DIV;
            end
            MD_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    st_next = MD_FIN;
                end
            end
            MD_FIN: begin
                st_next = MD_IDLE;
            end
            default: begin
                st_next = MD_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_next  = cnt_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        uc_next   = uc_reg;
        neg_next  = neg_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        hit_next  = hit_reg;
        q_next    = q_reg;

        pc    = cnt_reg[1:0];
        pprev = pc - 2'd1;
        ah    = pc[1] ? ua_reg[63:32] : ua_reg[31:0];
        bh    = pc[0] ? ub_reg[63:32] : ub_reg[31:0];
        case (pprev)
            2'd0:    ppx = {64'd0, pp_reg};
            2'd3:    ppx = {pp_reg, 64'd0};
            default: ppx = {32'd0, pp_reg, 32'd0};
        endcase
        rem2 = {rem_reg, acc_reg[63]};
        ge   = rem2 >= {1'b0, uc_reg};
        qm   = acc_reg[63:0];

        unique case (st_reg)
            MD_IDLE: begin
                if (req.go) begin
                    ua_next  = mag(req.a);
                    ub_next  = mag(req.b);
                    uc_next  = mag(req.c);
                    neg_next = req.a[63] ^ req.b[63] ^ req.c[63];
                    acc_next = '0;
                    cnt_next = '0;
                    if (req.a == 64'sd0 || req.b == 64'sd0) begin
                        q_next    = '0;
                        hit_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end
            MD_MUL: begin
                pp_next = ah * bh;
                if (cnt_reg != 6'd0) begin
                    acc_next = acc_reg + ppx;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            MD_CHK: begin
                cnt_next = '0;
                rem_next = acc_reg[127:64];
                if (acc_reg[127:64] >= uc_reg) begin
                    hit_next  = 1'b1;
                    q_next    = neg_reg ? -LIM : LIM;
                    done_next = 1'b1;
                end
            end
            MD_DIV: begin
                rem_next = ge ? 64'(rem2 - {1'b0, uc_reg}) : rem2[63:0];
                acc_next = {acc_reg[127:64], acc_reg[62:0], ge};
                cnt_next = cnt_reg + 6'd1;
            end
            MD_FIN: begin
                hit_next = 1'b0;
                if (qm > 64'(LIM)) begin
                    hit_next = 1'b1;
                    qm       = 64'(LIM);
                end
                q_next    = neg_reg ? -$signed(qm) : $signed(qm);
                done_next = 1'b1;
            end
            default: begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg   <= MD_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        cnt_reg <= cnt_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        uc_reg  <= uc_next;
        neg_reg <= neg_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        hit_reg <= hit_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;
    assign rsp.q    = q_reg;

    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> st_reg == MD_IDLE)
        else $error("multiply-divide started while busy");

    a_done_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (q_reg <= LIM && q_reg >= -LIM))
        else $error("multiply-divide result out of range");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(st_reg) == MD_FIN || $past(st_reg) == MD_CHK
                      || ($past(st_reg) == MD_IDLE && $past(req.go))))
        else $error("multiply-divide done without a finishing step");

endmodule

`default_nettype wire

// ----- rtl/hermite_interpolation_eval.sv -----
// Hermite interpolation evaluator top level: node store, sequencer and
// result register. Uses hie_pkg and the shared unit hie_muldiv.
//
//  channel    | signals                                  | direction
//  request    | req_valid, req_stall, op .. query_point  | in (stall out)
//  response   | rsp_valid, rsp_stall, approx_value,status| out (stall in)
//  node_count | node_count_we, node_count_wdata          | in
//
// A load leaves the sequencer idle. An evaluate with distinct nodes takes
// n*(n-1)/2 compare steps plus n*(2n+4) multiply-divide passes (start, multiply
// steps, range check, a 64-step one-bit-a-cycle divider, finishing step, done;
// a zero factor ends a pass at its start, an overflow at the range check). The
// divider takes most of the time. req_stall is high while an evaluate is in
// progress. Reset clears control state and sets node_count to 1; stored nodes
// are undefined until loaded. A waiting result does not block a new request.
`default_nettype none

module hermite_interpolation_eval #(
    parameter int MAX_NODES = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic               op,
    input  wire logic [3:0]         node_index,
    input  wire logic signed [31:0] node_abscissa,
    input  wire logic signed [31:0] node_value,
    input  wire logic signed [31:0] node_slope,
    input  wire logic signed [31:0] query_point,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic signed [31:0]      approx_value,
    output logic [1:0]              status,
    input  wire logic               node_count_we,
    input  wire logic [4:0]         node_count_wdata
);
    import hie_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic signed [31:0] abs_mem [MAX_NODES];
    logic signed [31:0] val_mem [MAX_NODES];
    logic signed [31:0] slp_mem [MAX_NODES];

    logic signed [31:0] xa_q, ya_q, ma_q, xb_q;

    state_t             state_reg, state_next;
    tag_t               tag_reg, tag_next;
    logic [4:0]         node_count_reg;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic signed [63:0] xq_reg, xq_next;
    logic signed [63:0] basis_reg, basis_next;
    logic signed [63:0] inv_reg, inv_next;
    logic signed [63:0] d_reg, d_next;
    logic signed [63:0] t_reg, t_next;
    logic signed [63:0] aval_reg, aval_next;
    logic signed [63:0] bval_reg, bval_next;
    logic signed [63:0] va_reg, va_next;
    logic signed [63:0] sum_reg, sum_next;
    logic               clamp_reg, clamp_next;
    logic               coinc_reg, coinc_next;
    md_req_t            md_req_reg, md_req_next;
    md_rsp_t            md_rsp;

    logic               rsp_valid_reg, rsp_valid_next;
    logic signed [31:0] out_val_reg, out_val_next;
    logic [1:0]         out_st_reg, out_st_next;

    logic               accept;
    logic               slot_free;
    logic [CW:0]        i_inc, j_inc;
    logic signed [63:0] xa64, xb64, ya64, ma64;
    sat_t               s1, s2;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign i_inc     = {1'b0, i_reg} + 1'b1;
    assign j_inc     = {1'b0, j_reg} + 1'b1;
    assign xa64      = {{32{xa_q[31]}}, xa_q};
    assign xb64      = {{32{xb_q[31]}}, xb_q};
    assign ya64      = {{32{ya_q[31]}}, ya_q};
    assign ma64      = {{32{ma_q[31]}}, ma_q};

    // Node store: one write port, reads at the node under work (i) and
    // the partner node (j), both registered.
    always_ff @(posedge clk) begin
        if (accept && op == OP_LOAD && 32'(node_index) < MAX_NODES) begin
            abs_mem[IW'(node_index)] <= node_abscissa;
            val_mem[IW'(node_index)] <= node_value;
            slp_mem[IW'(node_index)] <= node_slope;
        end
        xa_q <= abs_mem[i_reg[IW-1:0]];
        ya_q <= val_mem[i_reg[IW-1:0]];
        ma_q <= slp_mem[i_reg[IW-1:0]];
        xb_q <= abs_mem[j_reg[IW-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && op == OP_EVAL) begin
                    state_next = S_CHK_I;
                end
            end
            S_CHK_I: begin
                state_next = (i_inc >= {1'b0, n_reg}) ? S_EV_I : S_CHK_W;
            end
            S_CHK_W: begin
                state_next = S_CHK_C;
            end
            S_CHK_C: begin
                if (xa_q == xb_q) begin
                    state_next = S_OUT;
                end else if (j_inc < {1'b0, n_reg}) begin
                    state_next = S_CHK_W;
                end else begin
                    state_next = S_CHK_I;
                end
            end
            S_EV_I: begin
                state_next = (i_reg >= n_reg) ? S_OUT : S_EV_W;
            end
            S_EV_W: begin
                state_next = S_EV_J;
            end
            S_EV_J: begin
                if (j_reg >= n_reg) begin
                    state_next = S_MD;
                end else if (j_reg == i_reg) begin
                    state_next = S_EV_W;
                end else begin
                    state_next = S_MD;
                end
            end
            S_MD: begin
                if (md_rsp.done) begin
                    if (tag_reg == T_INV) begin
                        state_next = S_EV_W;
                    end else if (tag_reg == T_MB) begin
                        state_next = S_EV_I;
                    end
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        tag_next       = tag_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        xq_next        = xq_reg;
        basis_next     = basis_reg;
        inv_next       = inv_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        aval_next      = aval_reg;
        bval_next      = bval_reg;
        va_next        = va_reg;
        sum_next       = sum_reg;
        clamp_next     = clamp_reg;
        coinc_next     = coinc_reg;
        md_req_next    = md_req_reg;
        md_req_next.go = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        s1             = sat_add(md_rsp.q, md_rsp.q);
        s2             = sat_add(ONE, -s1.val);

        unique case (state_reg)
            S_IDLE: begin
                if (accept && op == OP_EVAL) begin
                    xq_next    = {{32{query_point[31]}}, query_point};
                    n_next     = (32'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES)
                                                                   : CW'(node_count_reg);
                    i_next     = '0;
                    sum_next   = '0;
                    clamp_next = 1'b0;
                    coinc_next = 1'b0;
                end
            end
            S_CHK_I: begin
                if (i_inc >= {1'b0, n_reg}) begin
                    i_next = '0;
                end else begin
                    j_next = i_inc[CW-1:0];
                end
            end
            S_CHK_W: begin
                coinc_next = 1'b0;
            end
            S_CHK_C: begin
                if (xa_q == xb_q) begin
                    coinc_next = 1'b1;
                end else if (j_inc < {1'b0, n_reg}) begin
                    j_next = j_inc[CW-1:0];
                end else begin
                    i_next = i_inc[CW-1:0];
                end
            end
            S_EV_I: begin
                basis_next = ONE;
                inv_next   = '0;
                j_next     = '0;
            end
            S_EV_W: begin
                coinc_next = 1'b0;
            end
            S_EV_J: begin
                if (j_reg >= n_reg) begin
                    t_next      = xq_reg - xa64;
                    md_req_next = '{go: 1'b1, a: basis_reg, b: basis_reg, c: ONE};
                    tag_next    = T_SQ;
                end else if (j_reg == i_reg) begin
                    j_next = j_inc[CW-1:0];
                end else begin
                    d_next      = xa64 - xb64;
                    md_req_next = '{go: 1'b1, a: basis_reg, b: xq_reg - xb64,
                                    c: xa64 - xb64};
                    tag_next    = T_BASIS;
                end
            end
            S_MD: begin
                if (md_rsp.done) begin
                    clamp_next = clamp_reg | md_rsp.hit;
                    case (tag_reg)
                        T_BASIS: begin
                            basis_next  = md_rsp.q;
                            md_req_next = '{go: 1'b1, a: ONE, b: ONE, c: d_reg};
                            tag_next    = T_INV;
                        end
                        T_INV: begin
                            s1         = sat_add(inv_reg, md_rsp.q);
                            inv_next   = s1.val;
                            clamp_next = clamp_reg | md_rsp.hit | s1.hit;
                            j_next     = j_inc[CW-1:0];
                        end
                        T_SQ: begin
                            basis_next  = md_rsp.q;
                            md_req_next = '{go: 1'b1, a: t_reg, b: inv_reg, c: ONE};
                            tag_next    = T_U;
                        end
                        T_U: begin
                            // u = 2 (x - x_i) S_i, then 1 - u, both saturating.
                            clamp_next  = clamp_reg | md_rsp.hit | s1.hit | s2.hit;
                            md_req_next = '{go: 1'b1, a: s2.val, b: basis_reg, c: ONE};
                            tag_next    = T_A;
                        end
                        T_A: begin
                            aval_next   = md_rsp.q;
                            md_req_next = '{go: 1'b1, a: t_reg, b: basis_reg, c: ONE};
                            tag_next    = T_B;
                        end
                        T_B: begin
                            bval_next   = md_rsp.q;
                            md_req_next = '{go: 1'b1, a: ya64, b: aval_reg, c: ONE};
                            tag_next    = T_VA;
                        end
                        T_VA: begin
                            va_next     = md_rsp.q;
                            md_req_next = '{go: 1'b1, a: ma64, b: bval_reg, c: ONE};
                            tag_next    = T_MB;
                        end
                        T_MB: begin
                            s1         = sat_add(va_reg, md_rsp.q);
                            s2         = sat_add(sum_reg, s1.val);
                            sum_next   = s2.val;
                            clamp_next = clamp_reg | md_rsp.hit | s1.hit | s2.hit;
                            i_next     = i_inc[CW-1:0];
                        end
                        default: begin
                            tag_next = T_BASIS;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    rsp_valid_next = 1'b1;
                    if (coinc_reg) begin
                        out_val_next = '0;
                        out_st_next  = ST_COINC;
                    end else if (sum_reg > 64'(OUT_MAX)) begin
                        out_val_next = OUT_MAX;
                        out_st_next  = ST_SAT;
                    end else if (sum_reg < 64'(OUT_MIN)) begin
                        out_val_next = OUT_MIN;
                        out_st_next  = ST_SAT;
                    end else begin
                        out_val_next = sum_reg[31:0];
                        out_st_next  = clamp_reg ? ST_SAT : ST_OK;
                    end
                end
            end
            default: begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            node_count_reg <= 5'd1;
            rsp_valid_reg  <= 1'b0;
            md_req_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            md_req_reg    <= md_req_next;
            if (node_count_we) begin
                node_count_reg <= node_count_wdata;
            end
        end
    end

    always_ff @(posedge clk) begin
        tag_reg      <= tag_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        xq_reg       <= xq_next;
        basis_reg    <= basis_next;
        inv_reg      <= inv_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        aval_reg     <= aval_next;
        bval_reg     <= bval_next;
        va_reg       <= va_next;
        sum_reg      <= sum_next;
        clamp_reg    <= clamp_next;
        coinc_reg    <= coinc_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
    end

    hie_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req_reg),
        .rsp   (md_rsp)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign approx_value = out_val_reg;
    assign status       = out_st_reg;

    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_COINC) |-> approx_value == 32'sd0)
        else $error("coincident-node beat carries a nonzero value");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_LOAD) |=> state_reg == S_IDLE)
        else $error("node load left the idle state");

    a_go_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_req_reg.go |-> state_reg == S_MD)
        else $error("multiply-divide issued outside its wait state");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == S_MD)
        else $error("multiply-divide finished with no operation pending");

endmodule

`default_nettype wire

// ----- test/tb_hermite_interpolation_eval.sv -----
// Self-checking testbench for hermite_interpolation_eval: directed table, then
// random loads and evaluations at several node counts, against a local predictor.
// Depends on hie_pkg and the hermite_interpolation_eval RTL only.
`timescale 1ns / 100ps

module tb_hermite_interpolation_eval;
    import hie_pkg::*;

    localparam int          SLOTS       = 16;
    localparam longint      ONE_Q       = 64'sd65536;
    localparam int          CYCLE_LIMIT = 10_000_000;
    localparam int          SETTLE      = 40;
    localparam logic signed [127:0] LIM_W = LIM;

    typedef enum logic [1:0] {K_LOAD, K_EVAL, K_CNT} kind_t;

    typedef struct {
        kind_t                  kind;
        logic [4:0]             cnt;
        logic [3:0]             idx;
        logic signed [31:0]     x;
        logic signed [31:0]     y;
        logic signed [31:0]     m;
        logic signed [31:0]     q;
        bit                     typed;
        logic signed [31:0]     ev;
        logic [1:0]             es;
    } row_t;

    typedef struct {
        logic signed [31:0] v;
        logic [1:0]         s;
    } approx_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    logic                    op = OP_LOAD;
    logic [3:0]              node_index = '0;
    logic signed [31:0]      node_abscissa = '0;
    logic signed [31:0]      node_value = '0;
    logic signed [31:0]      node_slope = '0;
    logic signed [31:0]      query_point = '0;
    logic                    rsp_valid;
    logic                    rsp_stall = 1'b0;
    logic signed [31:0]      approx_value;
    logic [1:0]              status;
    logic                    node_count_we = 1'b0;
    logic [4:0]              node_count_wdata = '0;

    // Local copy of the node store and the node count.
    logic signed [31:0]      abs_mem [SLOTS];
    logic signed [31:0]      val_mem [SLOTS];
    logic signed [31:0]      slp_mem [SLOTS];
    logic [4:0]              used_count = 5'd1;
    bit                      clamp_seen;
    approx_t                 pending_q [$];
    int                      errors = 0;
    bit                      quiet = 1'b0;
    int                      cycles = 0;

    row_t plan [0:20] = '{
        '{K_LOAD, 0, 0, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 0, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h0000_0000, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0, ST_OK},
        '{K_LOAD, 0, 1, 32'h0001_0000, 0, 0, 0, 0, 0, ST_OK},
        '{K_CNT, 2, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h0000_0000, 1, 0, ST_COINC},
        '{K_LOAD, 0, 1, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFE_0000, 0, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h0000_8000, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h0003_0000, 0, 0, ST_OK},
        '{K_LOAD, 0, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, ST_OK},
        '{K_LOAD, 0, 3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, ST_OK},
        '{K_CNT, 4, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h0000_0000, 0, 0, ST_OK},
        '{K_CNT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h0000_1234, 1, 0, ST_OK},
        '{K_LOAD, 0, 15, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 0, 0, 0, ST_OK},
        '{K_LOAD, 0, 4, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, ST_OK},
        '{K_CNT, 5, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{K_EVAL, 0, 0, 0, 0, 0, 32'h0001_8000, 0, 0, ST_OK}
    };

    hermite_interpolation_eval uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .op               (op),
        .node_index       (node_index),
        .node_abscissa    (node_abscissa),
        .node_value       (node_value),
        .node_slope       (node_slope),
        .query_point      (query_point),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .approx_value     (approx_value),
        .status           (status),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clip(input longint v);
        if (v > LIM)
        begin
            clamp_seen = 1'b1;
            return LIM;
        end
        if (v < -LIM)
        begin
            clamp_seen = 1'b1;
            return -LIM;
        end
        return v;
    endfunction

    // Exact a*b/c, truncated toward zero, then clipped to the internal range.
    function automatic longint scale(input longint a, input longint b, input longint c);
        logic signed [127:0] wa, wb, wc, quo;
        if (a == 0 || b == 0)
            return 0;
        wa  = a;
        wb  = b;
        wc  = c;
        quo = (wa * wb) / wc;
        if (quo > LIM_W)
        begin
            clamp_seen = 1'b1;
            return LIM;
        end
        if (quo < -LIM_W)
        begin
            clamp_seen = 1'b1;
            return -LIM;
        end
        return quo[63:0];
    endfunction

    function automatic approx_t hermite_at(input logic signed [31:0] qp);
        approx_t res;
        int      n;
        longint  xq, xi, xj, basis, inv, t, u, a, b, sum;
        n   = (used_count > SLOTS) ? SLOTS : int'(used_count);
        res = '{v: 0, s: ST_OK};
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (abs_mem[i] == abs_mem[j])
                    res.s = ST_COINC;
        if (res.s == ST_COINC)
            return res;
        clamp_seen = 1'b0;
        xq  = qp;
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            xi    = abs_mem[i];
            basis = ONE_Q;
            inv   = 0;
            for (int j = 0; j < n; j++)
            begin
                if (j == i)
                    continue;
                xj    = abs_mem[j];
                basis = scale(basis, xq - xj, xi - xj);
                inv   = clip(inv + scale(ONE_Q, ONE_Q, xi - xj));
            end
            basis = scale(basis, basis, ONE_Q);
            t     = xq - xi;
            u     = scale(t, inv, ONE_Q);
            u     = clip(u + u);
            a     = scale(clip(ONE_Q - u), basis, ONE_Q);
            b     = scale(t, basis, ONE_Q);
            sum   = clip(sum + clip(scale(longint'(val_mem[i]), a, ONE_Q)
                                    + scale(longint'(slp_mem[i]), b, ONE_Q)));
        end
        if (sum > longint'(OUT_MAX))
        begin
            sum        = OUT_MAX;
            clamp_seen = 1'b1;
        end
        if (sum < longint'(OUT_MIN))
        begin
            sum        = OUT_MIN;
            clamp_seen = 1'b1;
        end
        res.v = sum[31:0];
        res.s = clamp_seen ? ST_SAT : ST_OK;
        return res;
    endfunction

    // Drives one request beat and records what it should produce once accepted.
    task automatic send_beat(input row_t r);
        if (!quiet && $urandom_range(99) < 16)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid     <= 1'b1;
        op            <= (r.kind == K_EVAL) ? OP_EVAL : OP_LOAD;
        node_index    <= r.idx;
        node_abscissa <= r.x;
        node_value    <= r.y;
        node_slope    <= r.m;
        query_point   <= r.q;
        do
            @(posedge clk);
        while (req_stall);
        if (r.kind == K_LOAD)
        begin
            abs_mem[r.idx] = r.x;
            val_mem[r.idx] = r.y;
            slp_mem[r.idx] = r.m;
        end
        else if (r.typed)
            pending_q.push_back('{v: r.ev, s: r.es});
        else
            pending_q.push_back(hermite_at(r.q));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(input logic [4:0] cnt);
        drain();
        node_count_we    <= 1'b1;
        node_count_wdata <= cnt;
        @(posedge clk);
        node_count_we <= 1'b0;
        used_count = cnt;
    endtask

    function automatic logic signed [31:0] pick_small(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic row_t random_row(input int n);
        row_t r;
        r = '{kind: K_LOAD, cnt: 0, idx: 0, x: 0, y: 0, m: 0, q: 0,
              typed: 0, ev: 0, es: ST_OK};
        if ($urandom_range(1) == 1)
        begin
            r.kind = K_EVAL;
            r.q = ($urandom_range(9) < 6) ? pick_small(32'h0008_0000) : 32'($urandom);
        end
        else
        begin
            r.idx = ($urandom_range(9) < 7) ? 4'($urandom_range(n - 1)) : 4'($urandom);
            case ($urandom_range(19))
                0, 1, 2:
                    r.x = abs_mem[$urandom_range(n - 1)];
                3, 4, 5, 6:
                    r.x = 32'($urandom);
                default:
                    r.x = 32'($signed($urandom_range(0, 64)) - 32) <<< 14;
            endcase
            r.y = ($urandom_range(9) < 6) ? pick_small(32'h0010_0000) : 32'($urandom);
            r.m = ($urandom_range(9) < 6) ? pick_small(32'h0010_0000) : 32'($urandom);
        end
        return r;
    endfunction

    // Response side: check every accepted beat, then choose the next stall.
    initial
    begin
        approx_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result: value %h status %0d",
                                 approx_value, status);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (approx_value !== want.v || status !== want.s)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected %h/%0d, got %h/%0d",
                                     want.v, want.s, approx_value, status);
                    end
                end
            end
            rsp_stall <= !quiet && ($urandom_range(99) < 16);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        row_t r;
        int   n;
        int   sent;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == K_CNT)
                set_count(plan[k].cnt);
            else
                send_beat(plan[k]);
        end

        // Fill every slot so that any node count reads only written nodes.
        for (int s = 0; s < SLOTS; s++)
        begin
            r      = random_row(SLOTS);
            r.kind = K_LOAD;
            r.idx  = 4'(s);
            r.x    = 32'($urandom);
            send_beat(r);
        end
        set_count(5'd16);
        r      = random_row(SLOTS);
        r.kind = K_EVAL;
        send_beat(r);
        set_count(5'd31);
        r.q = pick_small(32'h0004_0000);
        send_beat(r);

        sent = 0;
        while (sent < 70)
        begin
            n = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            set_count(5'(n));
            repeat ($urandom_range(6, 10))
            begin
                quiet = (sent >= 25 && sent < 45);
                send_beat(random_row(n));
                sent++;
            end
        end
        quiet = 1'b0;

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
